@@ hdl/llrg_pkg.sv @@
package llrg_pkg;

   // Default widths of the value and time paths.
   localparam int VALUE_WIDTH = 24;
   localparam int TIME_WIDTH  = 32;

   // Fixed field widths.
   localparam int FUNC_WIDTH      = 3;
   localparam int TICK_WIDTH      = 16;
   localparam int PERIOD_WIDTH    = 32;
   localparam int LOOP_WIDTH      = 16;
   localparam int SCALE_WIDTH     = 16;
   localparam int DELAY_WIDTH     = 32;
   localparam int CSR_ADDR_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH  = 32;

   // Register reset values and the free-run wrap point (255.0 in Q15.8).
   localparam logic [SCALE_WIDTH-1:0] TIME_SCALE_RESET = 16'd256;
   localparam int WRAP_TOP = 255 * 256;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_TICK  = 3'd0,
      FUNC_TIMED = 3'd1,
      FUNC_RATE  = 3'd2,
      FUNC_FREE  = 3'd3,
      FUNC_STOP  = 3'd4
   } func_type;

   typedef enum logic [CSR_ADDR_WIDTH-1:0] {
      CSR_TIME_SCALE  = 2'd0,
      CSR_PING_PONG   = 2'd1,
      CSR_START_DELAY = 2'd2
   } csr_addr_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_FREE,
      ST_TIME,
      ST_DIV,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      MDU_IDLE,
      MDU_MUL,
      MDU_DIV
   } mdu_phase_type;

   typedef struct packed {
      logic start;
      logic rate_mode;
   } mdu_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } mdu_status_type;

endpackage

@@ hdl/llrg_if.sv @@
interface llrg_req_if #(
   parameter int VW = llrg_pkg::VALUE_WIDTH
);
   logic                                  valid;
   logic                                  ready;
   logic [llrg_pkg::FUNC_WIDTH-1:0]       func;
   logic [llrg_pkg::TICK_WIDTH-1:0]       delta_ticks;
   logic signed [VW-1:0]                  target_value;
   logic [llrg_pkg::PERIOD_WIDTH-1:0]     period_ticks;
   logic signed [llrg_pkg::LOOP_WIDTH-1:0] loop_count;
   logic signed [VW-1:0]                  rate;

   modport source (output valid, func, delta_ticks, target_value, period_ticks,
                   loop_count, rate, input ready);
   modport sink (input valid, func, delta_ticks, target_value, period_ticks,
                 loop_count, rate, output ready);
endinterface

interface llrg_rsp_if #(
   parameter int VW = llrg_pkg::VALUE_WIDTH
);
   logic                 valid;
   logic                 ready;
   logic signed [VW-1:0] value;
   logic                 running;

   modport source (output valid, value, running, input ready);
   modport sink (input valid, value, running, output ready);
endinterface

interface llrg_csr_if;
   logic                                valid;
   logic                                ready;
   logic [llrg_pkg::CSR_ADDR_WIDTH-1:0] addr;
   logic [llrg_pkg::CSR_DATA_WIDTH-1:0] data;

   modport source (output valid, addr, data, input ready);
   modport sink (input valid, addr, data, output ready);
endinterface

@@ hdl/llrg_mdu.sv @@
// Bit-serial multiply then divide unit.
// Ramp mode: quotient = (mag * mult) / divisor, one multiplier bit per cycle
// followed by one quotient bit per cycle. Rate mode: quotient = mag / divisor.
module llrg_mdu #(
   parameter int VW = llrg_pkg::VALUE_WIDTH,
   parameter int TW = llrg_pkg::TIME_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  llrg_pkg::mdu_cmd_type         cmd,
   input  logic [VW-1:0]                 mag,
   input  logic [TW-1:0]                 mult,
   input  logic [((TW > VW) ? TW : VW)-1:0] divisor,
   output llrg_pkg::mdu_status_type      status,
   output logic [VW-1:0]                 quot
);

   localparam int RW = (TW > VW) ? TW : VW;
   localparam int PW = RW + VW;
   localparam int CW = $clog2(RW + 1);

   llrg_pkg::mdu_phase_type phase_ff, phase_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [PW-1:0]           p_ff, p_in;
   logic [VW-1:0]           mag_ff, mag_in;
   logic [RW-1:0]           div_ff, div_in;

   logic [VW:0]  mul_sum;
   logic [RW:0]  div_trial;
   logic         div_ge;
   logic [RW:0]  div_rem;

   // One shift-add step on the upper product half.
   assign mul_sum = (VW + 1)'(p_ff[TW+VW-1:TW]) + (p_ff[0] ? (VW + 1)'(mag_ff) : '0);

   // One restoring division step.
   assign div_trial = {p_ff[PW-1:VW], p_ff[VW-1]};
   assign div_ge    = div_trial >= {1'b0, div_ff};
   assign div_rem   = div_ge ? (div_trial - {1'b0, div_ff}) : div_trial;

   // Sequencing and datapath of the shared register.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      p_in     = p_ff;
      mag_in   = mag_ff;
      div_in   = div_ff;
      case (phase_ff)
         llrg_pkg::MDU_IDLE: begin
            if (cmd.start) begin
               mag_in = mag;
               div_in = divisor;
               if (cmd.rate_mode) begin
                  phase_in = llrg_pkg::MDU_DIV;
                  cnt_in   = CW'(VW);
                  p_in     = PW'(mag);
               end else begin
                  phase_in = llrg_pkg::MDU_MUL;
                  cnt_in   = CW'(TW);
                  p_in     = PW'(mult);
               end
            end
         end
         llrg_pkg::MDU_MUL: begin
            p_in = PW'({mul_sum, p_ff[TW-1:1]});
            if (cnt_ff == CW'(1)) begin
               phase_in = llrg_pkg::MDU_DIV;
               cnt_in   = CW'(VW);
            end else begin
               cnt_in = cnt_ff - CW'(1);
            end
         end
         llrg_pkg::MDU_DIV: begin
            p_in = {div_rem[RW-1:0], p_ff[VW-2:0], div_ge};
            if (cnt_ff == CW'(1)) begin
               phase_in = llrg_pkg::MDU_IDLE;
            end
            cnt_in = cnt_ff - CW'(1);
         end
         default: begin
            phase_in = llrg_pkg::MDU_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= llrg_pkg::MDU_IDLE;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
      p_ff   <= p_in;
      mag_ff <= mag_in;
      div_ff <= div_in;
   end

   assign status.busy = (phase_ff != llrg_pkg::MDU_IDLE);
   assign status.done = (phase_ff == llrg_pkg::MDU_DIV) && (cnt_ff == CW'(1));
   assign quot        = p_in[VW-1:0];

endmodule

@@ hdl/looping_linear_ramp_generator.sv @@
// Stop, start and inactive or delayed ticks go through EXEC and DONE from accept to result.
// A free-run tick adds FREE; a positive-rate start adds DIV for the bit-serial divide;
// a ramp tick before the period ends adds TIME, then DIV for the bit-serial unit. One item
// at a time: a new item is taken in IDLE, once the last result is in the result register.
// Synchronous active-high reset clears the sequencer, ramp state, ping-pong and start delay, sets time_scale to 256,
// and empties the result register.
module looping_linear_ramp_generator #(
   parameter int VW = llrg_pkg::VALUE_WIDTH,
   parameter int TW = llrg_pkg::TIME_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   llrg_req_if.sink     req_chan,
   llrg_rsp_if.source   rsp_chan,
   llrg_csr_if.sink     csr_chan
);

   localparam int RW = (TW > VW) ? TW : VW;
   localparam int XW = (TW > 32) ? TW : 32;
   localparam int EW = ((TW > 24) ? TW : 24) + 1;
   localparam int DW = (TW > 16) ? TW : 16;
   localparam int FW = VW + 18;
   localparam logic [TW-1:0] TMAX = {TW{1'b1}};
   localparam logic signed [FW-1:0] WRAP_W = FW'(llrg_pkg::WRAP_TOP);

   // Sequencer and configuration.
   llrg_pkg::state_type state_ff, state_in;
   logic [15:0]          ts_ff;
   logic                 pp_ff;
   logic [31:0]          sd_ff;

   // Latched item.
   llrg_pkg::func_type   func_ff;
   logic [15:0]          dt_ff;
   logic signed [VW-1:0] tgt_ff;
   logic [31:0]          per_ff;
   logic signed [15:0]   lc_ff;
   logic signed [VW-1:0] rate_ff;

   // Ramp state.
   logic signed [VW-1:0] cur_ff, cur_in, start_ff, start_in, end_ff, end_in;
   logic signed [VW-1:0] step_ff, step_in;
   logic [TW-1:0]        elapsed_ff, elapsed_in, period_ff, period_in, delay_ff, delay_in;
   logic signed [15:0]   loops_ff, loops_in;
   logic                 active_ff, active_in, free_ff, free_in;
   logic                 rate_mode_ff, rate_mode_in, neg_ff, neg_in;

   // Registered products.
   logic signed [VW+16:0] prod_ff;
   logic [23:0]           inc_ff;
   logic [31:0]           scaled;

   // Result register.
   logic                 rsp_valid_ff;
   logic signed [VW-1:0] rsp_value_ff;
   logic                 rsp_running_ff;
   logic                 rsp_free;

   // Datapath terms.
   logic [TW-1:0]        per_sat, dly_sat, esat;
   logic [EW-1:0]        esum;
   logic [VW:0]          diff_w, diff_n, dist_w, dist_n, val_w;
   logic [VW-1:0]        diff_mag, dist_mag;
   logic signed [FW-1:0] fr_sum;
   logic [TW-1:0]        q_period;

   llrg_pkg::mdu_cmd_type    mdu_cmd;
   llrg_pkg::mdu_status_type mdu_status;
   logic [VW-1:0]            mdu_mag;
   logic [RW-1:0]            mdu_div;
   logic [VW-1:0]            mdu_quot;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Saturation of loaded times to the time maximum.
   assign per_sat = (XW'(per_ff) > XW'(TMAX)) ? TMAX : TW'(XW'(per_ff));
   assign dly_sat = (XW'(sd_ff) > XW'(TMAX)) ? TMAX : TW'(XW'(sd_ff));

   // Elapsed time advance, saturating.
   assign scaled = 32'(dt_ff) * 32'(ts_ff);
   assign esum   = EW'(elapsed_ff) + EW'(inc_ff);
   assign esat   = (esum > EW'(TMAX)) ? TMAX : TW'(esum);

   // Ramp distance and rate-start distance as sign and magnitude.
   assign diff_w   = {end_ff[VW-1], end_ff} - {start_ff[VW-1], start_ff};
   assign diff_n   = -diff_w;
   assign diff_mag = diff_w[VW] ? diff_n[VW-1:0] : diff_w[VW-1:0];
   assign dist_w   = {tgt_ff[VW-1], tgt_ff} - {cur_ff[VW-1], cur_ff};
   assign dist_n   = -dist_w;
   assign dist_mag = dist_w[VW] ? dist_n[VW-1:0] : dist_w[VW-1:0];

   // Free-run sum and the interpolated value.
   assign fr_sum   = FW'(cur_ff) + FW'(prod_ff);
   assign val_w    = {start_ff[VW-1], start_ff}
                   + (neg_ff ? -{1'b0, mdu_quot} : {1'b0, mdu_quot});
   assign q_period = (RW'(mdu_quot) > RW'(TMAX)) ? TMAX : TW'(RW'(mdu_quot));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         llrg_pkg::ST_IDLE: begin
            if (req_chan.valid) state_in = llrg_pkg::ST_EXEC;
         end
         llrg_pkg::ST_EXEC: begin
            state_in = llrg_pkg::ST_DONE;
            case (func_ff)
               llrg_pkg::FUNC_TICK: begin
                  if (active_ff && delay_ff == '0) begin
                     state_in = free_ff ? llrg_pkg::ST_FREE : llrg_pkg::ST_TIME;
                  end
               end
               llrg_pkg::FUNC_RATE: begin
                  if (!rate_ff[VW-1] && rate_ff != '0) state_in = llrg_pkg::ST_DIV;
               end
               default: begin
                  state_in = llrg_pkg::ST_DONE;
               end
            endcase
         end
         llrg_pkg::ST_FREE: begin
            state_in = llrg_pkg::ST_DONE;
         end
         llrg_pkg::ST_TIME: begin
            state_in = (esat >= period_ff) ? llrg_pkg::ST_DONE : llrg_pkg::ST_DIV;
         end
         llrg_pkg::ST_DIV: begin
            if (mdu_status.done) state_in = llrg_pkg::ST_DONE;
         end
         llrg_pkg::ST_DONE: begin
            if (rsp_free) state_in = llrg_pkg::ST_IDLE;
         end
         default: begin
            state_in = llrg_pkg::ST_IDLE;
         end
      endcase
   end

   // Handshake and unit launch.
   always_comb begin
      req_chan.ready    = (state_ff == llrg_pkg::ST_IDLE);
      mdu_cmd.start     = 1'b0;
      mdu_cmd.rate_mode = 1'b0;
      mdu_mag           = diff_mag;
      mdu_div           = RW'(period_ff);
      case (state_ff)
         llrg_pkg::ST_EXEC: begin
            mdu_cmd.start     = (state_in == llrg_pkg::ST_DIV);
            mdu_cmd.rate_mode = 1'b1;
            mdu_mag           = dist_mag;
            mdu_div           = RW'($unsigned(rate_ff));
         end
         llrg_pkg::ST_TIME: begin
            mdu_cmd.start = (state_in == llrg_pkg::ST_DIV);
         end
         default: begin
            mdu_cmd.start = 1'b0;
         end
      endcase
   end

   // Ramp state updates.
   always_comb begin
      cur_in       = cur_ff;
      start_in     = start_ff;
      end_in       = end_ff;
      step_in      = step_ff;
      elapsed_in   = elapsed_ff;
      period_in    = period_ff;
      delay_in     = delay_ff;
      loops_in     = loops_ff;
      active_in    = active_ff;
      free_in      = free_ff;
      rate_mode_in = rate_mode_ff;
      neg_in       = neg_ff;
      case (state_ff)
         llrg_pkg::ST_EXEC: begin
            case (func_ff)
               llrg_pkg::FUNC_TICK: begin
                  if (active_ff && delay_ff != '0) begin
                     delay_in = (DW'(delay_ff) > DW'(dt_ff))
                              ? TW'(DW'(delay_ff) - DW'(dt_ff)) : '0;
                  end
               end
               llrg_pkg::FUNC_TIMED, llrg_pkg::FUNC_RATE: begin
                  loops_in   = lc_ff;
                  start_in   = cur_ff;
                  end_in     = tgt_ff;
                  elapsed_in = '0;
                  active_in  = 1'b1;
                  free_in    = 1'b0;
                  delay_in   = dly_sat;
                  if (func_ff == llrg_pkg::FUNC_TIMED) begin
                     period_in = per_sat;
                  end else begin
                     step_in      = rate_ff;
                     rate_mode_in = 1'b1;
                     if (rate_ff == '0) period_in = TMAX;
                     else if (rate_ff[VW-1]) period_in = '0;
                  end
               end
               llrg_pkg::FUNC_FREE: begin
                  step_in   = rate_ff;
                  free_in   = 1'b1;
                  active_in = 1'b1;
                  delay_in  = dly_sat;
               end
               llrg_pkg::FUNC_STOP: begin
                  active_in = 1'b0;
               end
               default: begin
                  active_in = active_ff;
               end
            endcase
         end
         llrg_pkg::ST_FREE: begin
            if (fr_sum > WRAP_W) cur_in = '0;
            else if (fr_sum < 0) cur_in = VW'(WRAP_W);
            else cur_in = VW'(fr_sum);
         end
         llrg_pkg::ST_TIME: begin
            elapsed_in = esat;
            if (esat >= period_ff) begin
               // Ramp end: hold the target, then repeat if loops remain.
               cur_in    = end_ff;
               active_in = 1'b0;
               if (loops_ff != '0) begin
                  if (!loops_ff[15]) loops_in = loops_ff - 16'sd1;
                  elapsed_in = '0;
                  active_in  = 1'b1;
                  free_in    = 1'b0;
                  if (pp_ff) begin
                     start_in = end_ff;
                     end_in   = start_ff;
                  end else begin
                     cur_in = start_ff;
                  end
               end
            end else begin
               rate_mode_in = 1'b0;
               neg_in       = diff_w[VW];
            end
         end
         llrg_pkg::ST_DIV: begin
            if (mdu_status.done) begin
               if (rate_mode_ff) period_in = q_period;
               else cur_in = val_w[VW-1:0];
            end
         end
         default: begin
            cur_in = cur_ff;
         end
      endcase
   end

   llrg_mdu #(
      .VW(VW),
      .TW(TW)
   ) u_llrg_mdu (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mdu_cmd),
      .mag     (mdu_mag),
      .mult    (esat),
      .divisor (mdu_div),
      .status  (mdu_status),
      .quot    (mdu_quot)
   );

   // Control, configuration and ramp state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= llrg_pkg::ST_IDLE;
         ts_ff          <= llrg_pkg::TIME_SCALE_RESET;
         pp_ff          <= 1'b0;
         sd_ff          <= '0;
         cur_ff         <= '0;
         start_ff       <= '0;
         end_ff         <= '0;
         step_ff        <= '0;
         elapsed_ff     <= '0;
         period_ff      <= '0;
         delay_ff       <= '0;
         loops_ff       <= '0;
         active_ff      <= 1'b0;
         free_ff        <= 1'b0;
         rate_mode_ff   <= 1'b0;
         neg_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         start_ff     <= start_in;
         end_ff       <= end_in;
         step_ff      <= step_in;
         elapsed_ff   <= elapsed_in;
         period_ff    <= period_in;
         delay_ff     <= delay_in;
         loops_ff     <= loops_in;
         active_ff    <= active_in;
         free_ff      <= free_in;
         rate_mode_ff <= rate_mode_in;
         neg_ff       <= neg_in;
         if (csr_chan.valid) begin
            case (llrg_pkg::csr_addr_type'(csr_chan.addr))
               llrg_pkg::CSR_TIME_SCALE:  ts_ff <= csr_chan.data[15:0];
               llrg_pkg::CSR_PING_PONG:   pp_ff <= csr_chan.data[0];
               llrg_pkg::CSR_START_DELAY: sd_ff <= csr_chan.data;
               default: ;
            endcase
         end
         if (state_ff == llrg_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item capture, products and result payload.
   always_ff @(posedge clock) begin
      if (req_chan.valid && state_ff == llrg_pkg::ST_IDLE) begin
         func_ff <= llrg_pkg::func_type'(req_chan.func);
         dt_ff   <= req_chan.delta_ticks;
         tgt_ff  <= req_chan.target_value;
         per_ff  <= req_chan.period_ticks;
         lc_ff   <= req_chan.loop_count;
         rate_ff <= req_chan.rate;
      end
      prod_ff <= step_ff * $signed({1'b0, dt_ff});
      inc_ff  <= scaled[31:8];
      if (state_ff == llrg_pkg::ST_DONE && rsp_free) begin
         rsp_value_ff   <= cur_ff;
         rsp_running_ff <= active_ff;
      end
   end

   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.value   = rsp_value_ff;
   assign rsp_chan.running = rsp_running_ff;

endmodule

@@ hdl/llrg_checker.sv @@
module llrg_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic csr_ready
);

   // Items accepted whose result has not been taken yet.
   logic [1:0] pend_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   // A waiting result stays offered until taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before taken");

   // No result without an item behind it.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without an accepted item");

   // At most one item in work besides one waiting result.
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many items outstanding");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Configuration writes are never stalled.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("configuration port stalled");

endmodule

bind looping_linear_ramp_generator llrg_checker u_llrg_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .csr_ready (csr_chan.ready)
);

@@ verif/tb.sv @@
module tb;

   localparam longint TIME_LIMIT     = 64'hFFFF_FFFF;
   localparam logic [2:0] FUNC_SPARE = 3'd7;
   localparam int STALL_LIMIT        = 20000;
   localparam int SETTLE_CYCLES      = 70;

   typedef struct {
      logic [2:0]         func;
      logic [15:0]        dt;
      logic signed [23:0] target;
      logic [31:0]        period;
      logic signed [15:0] loops;
      logic signed [23:0] rate;
   } ramp_cmd_type;

   typedef struct {
      logic [23:0] value;
      logic        running;
   } ramp_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   llrg_req_if req_if ();
   llrg_rsp_if rsp_if ();
   llrg_csr_if csr_if ();

   looping_linear_ramp_generator u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Expected ramp outputs, oldest first.
   ramp_out_type ramp_expect_q[$];
   int  error_count = 0;
   bit  quiet_mode = 1'b0;
   int  idle_cycles = 0;

   // Predicted ramp state and register copies.
   longint cur_val, ramp_from, ramp_to, free_step;
   longint elapsed_t, period_t, delay_t;
   int     loops_rem;
   bit     running, free_mode;
   longint scale_cfg, pp_cfg, delay_cfg;

   function automatic longint clamp_time(longint v);
      return (v > TIME_LIMIT) ? TIME_LIMIT : v;
   endfunction

   function automatic void launch_ramp(longint to, longint per);
      ramp_from = cur_val;
      ramp_to   = to;
      period_t  = per;
      elapsed_t = 0;
      running   = 1'b1;
      free_mode = 1'b0;
   endfunction

   function automatic void advance_time(longint dt);
      longint v, from, to;
      if (!running) return;
      if (delay_t > 0) begin
         delay_t = (delay_t > dt) ? delay_t - dt : 0;
         return;
      end
      if (free_mode) begin
         v = cur_val + free_step * dt;
         if (v > llrg_pkg::WRAP_TOP) v = 0;
         if (v < 0) v = llrg_pkg::WRAP_TOP;
         cur_val = v;
         return;
      end
      elapsed_t = clamp_time(elapsed_t + ((dt * scale_cfg) >>> 8));
      if (elapsed_t >= period_t) begin
         from    = ramp_from;
         to      = ramp_to;
         cur_val = to;
         running = 1'b0;
         if (loops_rem != 0) begin
            if (loops_rem > 0) loops_rem--;
            if (pp_cfg != 0) begin
               launch_ramp(from, period_t);
            end else begin
               cur_val = from;
               launch_ramp(to, period_t);
            end
         end
      end else begin
         cur_val = ramp_from + ((ramp_to - ramp_from) * elapsed_t) / period_t;
      end
   endfunction

   // Apply one command to the predicted state and return the expected output.
   function automatic ramp_out_type predict_ramp(ramp_cmd_type c);
      ramp_out_type r;
      longint       span, per;
      case (c.func)
         llrg_pkg::FUNC_TICK: advance_time(longint'(c.dt));
         llrg_pkg::FUNC_TIMED: begin
            loops_rem = c.loops;
            launch_ramp(longint'(c.target), clamp_time(longint'(c.period)));
            delay_t = clamp_time(delay_cfg);
         end
         llrg_pkg::FUNC_RATE: begin
            span = longint'(c.target) - cur_val;
            if (span < 0) span = -span;
            if (c.rate == 0) per = TIME_LIMIT;
            else if (c.rate < 0) per = 0;
            else per = clamp_time(span / longint'(c.rate));
            free_step = c.rate;
            loops_rem = c.loops;
            launch_ramp(longint'(c.target), per);
            delay_t = clamp_time(delay_cfg);
         end
         llrg_pkg::FUNC_FREE: begin
            free_step = c.rate;
            free_mode = 1'b1;
            running   = 1'b1;
            delay_t   = clamp_time(delay_cfg);
         end
         llrg_pkg::FUNC_STOP: running = 1'b0;
         default: ;
      endcase
      r.value   = cur_val[23:0];
      r.running = running;
      return r;
   endfunction

   // Track accepted commands and register writes, and check each result.
   always @(posedge clock) begin
      ramp_cmd_type c;
      ramp_out_type e;
      if (reset) begin
         cur_val = 0; ramp_from = 0; ramp_to = 0; free_step = 0;
         elapsed_t = 0; period_t = 0; delay_t = 0; loops_rem = 0;
         running = 1'b0; free_mode = 1'b0;
         scale_cfg = 256; pp_cfg = 0; delay_cfg = 0;
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.addr)
               llrg_pkg::CSR_TIME_SCALE:  scale_cfg = csr_if.data[15:0];
               llrg_pkg::CSR_PING_PONG:   pp_cfg = csr_if.data[0];
               llrg_pkg::CSR_START_DELAY: delay_cfg = csr_if.data;
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            c.func   = req_if.func;
            c.dt     = req_if.delta_ticks;
            c.target = req_if.target_value;
            c.period = req_if.period_ticks;
            c.loops  = req_if.loop_count;
            c.rate   = req_if.rate;
            ramp_expect_q.push_back(predict_ramp(c));
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (ramp_expect_q.size() == 0) begin
               $display("%0t: unexpected result value=%h running=%b", $time,
                        rsp_if.value, rsp_if.running);
               error_count++;
            end else begin
               e = ramp_expect_q.pop_front();
               if (rsp_if.value !== e.value) begin
                  $display("%0t: value expected %h actual %h", $time, e.value,
                           rsp_if.value);
                  error_count++;
               end
               if (rsp_if.running !== e.running) begin
                  $display("%0t: running expected %b actual %b", $time, e.running,
                           rsp_if.running);
                  error_count++;
               end
            end
         end
      end
   end

   // Result side back-pressure in random bursts.
   int rsp_stall = 0;
   always @(posedge clock) begin
      if (reset || quiet_mode) begin
         rsp_if.ready <= 1'b1;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_stall = $urandom_range(1, 17) - 1;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Watchdog on cycles with no handshake at all.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (ramp_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic send_cmd(ramp_cmd_type c);
      if (!quiet_mode && $urandom_range(0, 3) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.func         <= c.func;
      req_if.delta_ticks  <= c.dt;
      req_if.target_value <= c.target;
      req_if.period_ticks <= c.period;
      req_if.loop_count   <= c.loops;
      req_if.rate         <= c.rate;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic end_cmds();
      req_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes happen only with nothing in flight.
   task automatic write_reg(llrg_pkg::csr_addr_type addr, logic [31:0] data);
      end_cmds();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.addr  <= addr;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
   endtask

   function automatic ramp_cmd_type make_cmd(logic [2:0] f, logic [15:0] dt,
                                             logic signed [23:0] tgt, logic [31:0] per,
                                             logic signed [15:0] lp,
                                             logic signed [23:0] rt);
      ramp_cmd_type c;
      c.func = f; c.dt = dt; c.target = tgt; c.period = per; c.loops = lp; c.rate = rt;
      return c;
   endfunction

   function automatic ramp_cmd_type random_cmd();
      ramp_cmd_type c;
      int           pick;
      pick     = $urandom_range(0, 99);
      c.func   = (pick < 60) ? llrg_pkg::FUNC_TICK : (pick < 75) ? llrg_pkg::FUNC_TIMED :
                 (pick < 85) ? llrg_pkg::FUNC_RATE : (pick < 92) ? llrg_pkg::FUNC_FREE :
                 (pick < 97) ? llrg_pkg::FUNC_STOP : 3'($urandom_range(5, 7));
      c.dt     = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8));
      c.target = ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                 24'($signed($urandom_range(0, 16383)) - 8192);
      c.period = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      case ($urandom_range(0, 5))
         0: c.loops = -1;
         1: c.loops = 16'($urandom);
         default: c.loops = 16'($urandom_range(0, 3));
      endcase
      c.rate   = ($urandom_range(0, 4) == 0) ? 24'($urandom) :
                 24'($signed($urandom_range(0, 1023)) - 256);
      return c;
   endfunction

   // Start, stop, an unused code and extreme field values.
   task automatic test_command_extremes();
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 16'hFFFF, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TIMED, 0, 24'sh7FFFFF, 32'hFFFFFFFF, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 16'hFFFF, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TIMED, 0, -24'sh800000, 4, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 2, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 5, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_RATE, 0, 24'sh1000, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_RATE, 0, 24'sh1000, 0, 0, -24'sh800000));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 1, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_RATE, 0, 24'sh7FFFFF, 0, 0, 24'sh7FFFFF));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 1, 0, 0, 0, 0));
      send_cmd(make_cmd(FUNC_SPARE, 16'hFFFF, -1, 32'hFFFFFFFF, -1, -1));
   endtask

   // An endless loop in ping-pong mode and a counted loop in restart mode.
   task automatic test_loop_modes();
      write_reg(llrg_pkg::CSR_PING_PONG, 1);
      send_cmd(make_cmd(llrg_pkg::FUNC_TIMED, 0, 24'sh0400, 3, -1, 0));
      repeat (4) send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 2, 0, 0, 0, 0));
      write_reg(llrg_pkg::CSR_PING_PONG, 0);
      send_cmd(make_cmd(llrg_pkg::FUNC_TIMED, 0, -24'sh0400, 3, 16'sh7FFF, 0));
      repeat (3) send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 2, 0, 0, 0, 0));
   endtask

   // Free run wrapping above 255.0 and below zero.
   task automatic test_free_run_wrap();
      send_cmd(make_cmd(llrg_pkg::FUNC_FREE, 0, 0, 0, 0, 24'sh4000));
      repeat (5) send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 1, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_FREE, 0, 0, 0, 0, -24'sh4000));
      repeat (2) send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 1, 0, 0, 0, 0));
   endtask

   // Start delay at its maximum, burned only partly before a stop.
   task automatic test_start_delay();
      write_reg(llrg_pkg::CSR_START_DELAY, 32'hFFFFFFFF);
      send_cmd(make_cmd(llrg_pkg::FUNC_TIMED, 0, 24'sh0100, 2, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_TICK, 16'hFFFF, 0, 0, 0, 0));
      send_cmd(make_cmd(llrg_pkg::FUNC_STOP, 0, 0, 0, 0, 0));
   endtask

   // Random commands across several register settings.
   task automatic test_random_phases();
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: write_reg(llrg_pkg::CSR_TIME_SCALE, 0);
            1: write_reg(llrg_pkg::CSR_TIME_SCALE, 16'hFFFF);
            2: write_reg(llrg_pkg::CSR_START_DELAY, 0);
            3: write_reg(llrg_pkg::CSR_TIME_SCALE, 256);
            default: write_reg(llrg_pkg::csr_addr_type'($urandom_range(0, 2)),
                               $urandom_range(0, 3) == 0 ? $urandom :
                               $urandom_range(0, 600));
         endcase
         write_reg(llrg_pkg::CSR_PING_PONG, ph[0]);
         if (ph == 7) quiet_mode = 1'b1;
         for (int i = 0; i < 250; i++) begin
            send_cmd(random_cmd());
            // The sender holds once until every result is back.
            if (ph == 3 && i == 100) begin
               end_cmds();
               wait_drained();
            end
         end
      end
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.func = llrg_pkg::FUNC_TICK;
      req_if.delta_ticks = '0;
      req_if.target_value = '0;
      req_if.period_ticks = '0;
      req_if.loop_count = '0;
      req_if.rate = '0;
      csr_if.valid = 1'b0;
      csr_if.addr = llrg_pkg::CSR_TIME_SCALE;
      csr_if.data = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_command_extremes();
      test_loop_modes();
      test_free_run_wrap();
      test_start_delay();
      test_random_phases();
      end_cmds();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
